/* design/bcr_pkg.sv */
// ----------------------------------------------------------------------------
// bcr_pkg
// Types and constants shared by the bilinear crop resampler modules.
// ----------------------------------------------------------------------------
package bcr_pkg;

	localparam int SZ_W      = 8;
	localparam int CROW_W    = 7;
	localparam int FRAC_W    = 16;
	localparam int STEP_W    = SZ_W + FRAC_W;
	localparam int POS_W     = SZ_W + STEP_W;
	localparam int PIX_W     = 16;
	localparam int Q_W       = 16;
	localparam int W_W       = 2 * FRAC_W + 1;
	localparam int PROD_W    = W_W + Q_W - 1;
	localparam int ACC_W     = PROD_W + 1;
	localparam int NUM_NB    = 4;
	localparam int PADDR_W   = 5;
	localparam int IDX_MIN_W = 18;

	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_RESAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_SRC_HEIGHT,
		REG_SRC_WIDTH,
		REG_CROP_TOP,
		REG_CROP_LEFT,
		REG_CROP_HEIGHT,
		REG_CROP_WIDTH,
		REG_TARGET_HEIGHT,
		REG_TARGET_WIDTH
	} reg_idx_t;

	typedef struct packed {
		logic              kind;
		logic [15:0]       load_index;
		logic [15:0]       load_value;
		logic [CROW_W-1:0] out_row;
		logic [CROW_W-1:0] out_col;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  channel;
		logic [15:0] sample;
		logic        last;
		logic        window_error;
	} out_word_t;

	typedef struct packed {
		logic [SZ_W-1:0]   sh;
		logic [SZ_W-1:0]   sw;
		logic [SZ_W-1:0]   ch;
		logic [SZ_W-1:0]   cw;
		logic [SZ_W-1:0]   th;
		logic [SZ_W-1:0]   tw;
		logic [CROW_W-1:0] top;
		logic [CROW_W-1:0] left;
		logic [STEP_W-1:0] step_y;
		logic [STEP_W-1:0] step_x;
	} geom_t;

	typedef struct packed {
		logic                          kind;
		logic [15:0]                   load_index;
		logic [15:0]                   load_value;
		logic [NUM_NB-1:0][PIX_W-1:0]  pix;
		logic [NUM_NB-1:0][W_W-1:0]    w;
	} coord_t;

	typedef struct packed {
		logic [1:0]                   channel;
		logic                         last;
		logic                         window_error;
		logic [NUM_NB-1:0][W_W-1:0]   w;
		logic [NUM_NB-1:0][Q_W-1:0]   q;
	} blend_t;

endpackage

/* design/bcr_stepdiv.sv */
// ----------------------------------------------------------------------------
// bcr_stepdiv
// Restoring divider, one quotient bit per cycle, for the Q16 axis step.
// ----------------------------------------------------------------------------
module bcr_stepdiv import bcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] num,
	input  logic [SZ_W-1:0]   den,
	output logic              busy,
	output logic [STEP_W-1:0] quot
);

	localparam int CNT_W = $clog2(STEP_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SZ_W-1:0]  rem_q;
	logic [STEP_W-1:0] num_q;
	logic [SZ_W-1:0]  den_q;
	logic [STEP_W-1:0] quot_q;
	logic [SZ_W:0]    trial;
	logic [SZ_W:0]    diff;
	logic             qbit;

	assign trial = {rem_q, num_q[STEP_W-1]};
	assign qbit  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEP_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[SZ_W-1:0] : trial[SZ_W-1:0];
			num_q  <= {num_q[STEP_W-2:0], 1'b0};
			quot_q <= {quot_q[STEP_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

/* design/bcr_store.sv */
// ----------------------------------------------------------------------------
// bcr_store
// One copy of the frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bcr_store import bcr_pkg::*; #(
	parameter int DEPTH = 49152,
	parameter int AW    = 16
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  logic [Q_W-1:0] wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output logic [Q_W-1:0] rdata
);

	logic [Q_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/bcr_coord.sv */
// ----------------------------------------------------------------------------
// bcr_coord
// Five-stage coordinate pipeline: clamp, Q16 position, neighbour indices,
// absolute clamp and weights, pixel offsets.
// ----------------------------------------------------------------------------
module bcr_coord import bcr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  in_word_t in_word,
	input  geom_t    geom,
	output logic     out_valid,
	output coord_t   out_coord
);

	localparam int AX_W = 2 * SZ_W + FRAC_W;

	function automatic logic [AX_W-1:0] axis_map(input logic [POS_W-1:0] pos,
			input logic [SZ_W-1:0] crop);
		logic [SZ_W-1:0]   cm1;
		logic [SZ_W-1:0]   lo;
		logic [SZ_W-1:0]   hi;
		logic [FRAC_W-1:0] fr;
		cm1 = crop - SZ_W'(1);
		if (pos[POS_W-1:FRAC_W] > (POS_W-FRAC_W)'(cm1)) begin
			lo = cm1;
			fr = '0;
		end else begin
			lo = pos[FRAC_W+SZ_W-1:FRAC_W];
			fr = pos[FRAC_W-1:0];
		end
		hi = ((SZ_W+1)'(lo) + (SZ_W+1)'(1) < (SZ_W+1)'(crop)) ? lo + SZ_W'(1) : cm1;
		return {lo, hi, fr};
	endfunction

	function automatic logic [SZ_W-1:0] clamp_abs(input logic [CROW_W-1:0] base,
			input logic [SZ_W-1:0] off, input logic [SZ_W-1:0] lim);
		logic [SZ_W:0]   a;
		logic [SZ_W-1:0] lm1;
		a   = (SZ_W+1)'(base) + (SZ_W+1)'(off);
		lm1 = lim - SZ_W'(1);
		return (a > (SZ_W+1)'(lm1)) ? lm1 : a[SZ_W-1:0];
	endfunction

	function automatic logic [W_W-1:0] mulw(input logic [FRAC_W:0] a,
			input logic [FRAC_W:0] b);
		logic [2*FRAC_W+1:0] t;
		t = (2*FRAC_W+2)'(a) * (2*FRAC_W+2)'(b);
		return t[W_W-1:0];
	endfunction

	localparam logic [FRAC_W:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	in_word_t                    item_s1, item_s2, item_s3, item_s4;
	logic [SZ_W-1:0]             orow_s1, ocol_s1;
	logic [POS_W-1:0]            posy_s2, posx_s2;
	logic [SZ_W-1:0]             y0_s3, y1_s3, x0_s3, x1_s3;
	logic [FRAC_W-1:0]           fy_s3, fx_s3;
	logic [SZ_W-1:0]             ay0_s4, ay1_s4, ax0_s4, ax1_s4;
	logic [NUM_NB-1:0][W_W-1:0]  w_s4;
	coord_t                      coord_s5;

	logic [SZ_W-1:0]   thm1, twm1, orow_c, ocol_c;
	logic [AX_W-1:0]   ymap, xmap;
	logic [FRAC_W:0]   fxn, fyn;

	assign thm1   = geom.th - SZ_W'(1);
	assign twm1   = geom.tw - SZ_W'(1);
	assign orow_c = (SZ_W'(in_word.out_row) > thm1) ? thm1 : SZ_W'(in_word.out_row);
	assign ocol_c = (SZ_W'(in_word.out_col) > twm1) ? twm1 : SZ_W'(in_word.out_col);
	assign ymap   = axis_map(posy_s2, geom.ch);
	assign xmap   = axis_map(posx_s2, geom.cw);
	assign fyn    = ONE_Q - (FRAC_W+1)'(fy_s3);
	assign fxn    = ONE_Q - (FRAC_W+1)'(fx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_word;
			orow_s1 <= orow_c;
			ocol_s1 <= ocol_c;

			item_s2 <= item_s1;
			posy_s2 <= POS_W'(orow_s1) * POS_W'(geom.step_y);
			posx_s2 <= POS_W'(ocol_s1) * POS_W'(geom.step_x);

			item_s3 <= item_s2;
			{y0_s3, y1_s3, fy_s3} <= ymap;
			{x0_s3, x1_s3, fx_s3} <= xmap;

			item_s4 <= item_s3;
			ay0_s4  <= clamp_abs(geom.top, y0_s3, geom.sh);
			ay1_s4  <= clamp_abs(geom.top, y1_s3, geom.sh);
			ax0_s4  <= clamp_abs(geom.left, x0_s3, geom.sw);
			ax1_s4  <= clamp_abs(geom.left, x1_s3, geom.sw);
			w_s4[0] <= mulw(fxn, fyn);
			w_s4[1] <= mulw((FRAC_W+1)'(fx_s3), fyn);
			w_s4[2] <= mulw(fxn, (FRAC_W+1)'(fy_s3));
			w_s4[3] <= mulw((FRAC_W+1)'(fx_s3), (FRAC_W+1)'(fy_s3));

			coord_s5.kind       <= item_s4.kind;
			coord_s5.load_index <= item_s4.load_index;
			coord_s5.load_value <= item_s4.load_value;
			coord_s5.w          <= w_s4;
			coord_s5.pix[0] <= PIX_W'(ay0_s4) * PIX_W'(geom.sw) + PIX_W'(ax0_s4);
			coord_s5.pix[1] <= PIX_W'(ay0_s4) * PIX_W'(geom.sw) + PIX_W'(ax1_s4);
			coord_s5.pix[2] <= PIX_W'(ay1_s4) * PIX_W'(geom.sw) + PIX_W'(ax0_s4);
			coord_s5.pix[3] <= PIX_W'(ay1_s4) * PIX_W'(geom.sw) + PIX_W'(ax1_s4);
		end
	end

	assign out_valid = v_s5;
	assign out_coord = coord_s5;

endmodule

/* design/bcr_blend.sv */
// ----------------------------------------------------------------------------
// bcr_blend
// Weighted sum of the four neighbours: product stage, then sum, rounding
// and output register.
// ----------------------------------------------------------------------------
module bcr_blend import bcr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  blend_t    in_blend,
	output logic      out_valid,
	output out_word_t out_word
);

	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_W - 1);

	logic                          v_s8, v_s9;
	logic [NUM_NB-1:0][PROD_W-1:0] prod_s8;
	logic [1:0]                    ch_s8;
	logic                          last_s8, err_s8;
	out_word_t                     word_s9;
	logic [ACC_W-1:0]              acc;
	logic [ACC_W-2*FRAC_W-1:0]     rnd;

	assign acc = ACC_W'(prod_s8[0]) + ACC_W'(prod_s8[1]) + ACC_W'(prod_s8[2])
		+ ACC_W'(prod_s8[3]) + HALF;
	assign rnd = acc[ACC_W-1:2*FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= in_valid;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_NB; k++) begin
				prod_s8[k] <= PROD_W'(in_blend.w[k]) * PROD_W'(in_blend.q[k]);
			end
			ch_s8   <= in_blend.channel;
			last_s8 <= in_blend.last;
			err_s8  <= in_blend.window_error;

			word_s9.channel      <= ch_s8;
			word_s9.last         <= last_s8;
			word_s9.window_error <= err_s8;
			word_s9.sample       <= (rnd > (ACC_W-2*FRAC_W)'(16'hFFFF)) ? 16'hFFFF
				: rnd[Q_W-1:0];
		end
	end

	assign out_valid = v_s9;
	assign out_word  = word_s9;

endmodule

/* design/bilinear_crop_resampler.sv */
// ----------------------------------------------------------------------------
// bilinear_crop_resampler
// Frame store with a bilinear crop-and-resize read path.
//
//   channel  valid         stall         word      dir
//   item     item_valid    item_stall    item      in   (load or resample)
//   result   result_valid  result_stall  result    out  (one per channel)
//   config   psel/penable  pready        paddr...  APB, 8 registers
//
// At the channel sequencer a load is passed on at once, a resample is repeated
// for each channel (one four-port frame store read per channel); an accepted
// item passes the coordinate, sequencer, store read and blend stages in turn.
// After reset and after every register write item_stall stays high until
// both step dividers have been started and produced their 24 quotient bits.
// result_stall on a valid result freezes the pipeline; no drops, no repeats.
// ----------------------------------------------------------------------------
module bilinear_crop_resampler import bcr_pkg::*; #(
	parameter int MAX_DIM  = 128,
	parameter int CHANNELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  in_word_t           item,
	output logic               result_valid,
	input  logic               result_stall,
	output out_word_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DEPTH   = MAX_DIM * MAX_DIM * CHANNELS;
	localparam int AW      = $clog2(DEPTH);
	localparam int IDX_W   = (AW > IDX_MIN_W) ? AW : IDX_MIN_W;
	localparam int CNT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MAX_LIM = (MAX_DIM > 255) ? 255 : MAX_DIM;

	function automatic logic [SZ_W-1:0] size_eff(input logic [SZ_W-1:0] v);
		if (v == '0) begin
			return SZ_W'(1);
		end
		if (v > SZ_W'(MAX_LIM)) begin
			return SZ_W'(MAX_LIM);
		end
		return v;
	endfunction

	// registers
	logic [SZ_W-1:0]   src_height_q, src_width_q, crop_height_q, crop_width_q;
	logic [SZ_W-1:0]   target_height_q, target_width_q;
	logic [CROW_W-1:0] crop_top_q, crop_left_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_height_q    <= SZ_W'(128);
			src_width_q     <= SZ_W'(128);
			crop_top_q      <= '0;
			crop_left_q     <= '0;
			crop_height_q   <= SZ_W'(128);
			crop_width_q    <= SZ_W'(128);
			target_height_q <= SZ_W'(128);
			target_width_q  <= SZ_W'(128);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SRC_HEIGHT:    src_height_q    <= pwdata[SZ_W-1:0];
				REG_SRC_WIDTH:     src_width_q     <= pwdata[SZ_W-1:0];
				REG_CROP_TOP:      crop_top_q      <= pwdata[CROW_W-1:0];
				REG_CROP_LEFT:     crop_left_q     <= pwdata[CROW_W-1:0];
				REG_CROP_HEIGHT:   crop_height_q   <= pwdata[SZ_W-1:0];
				REG_CROP_WIDTH:    crop_width_q    <= pwdata[SZ_W-1:0];
				REG_TARGET_HEIGHT: target_height_q <= pwdata[SZ_W-1:0];
				REG_TARGET_WIDTH:  target_width_q  <= pwdata[SZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SRC_HEIGHT:    prdata = 32'(src_height_q);
			REG_SRC_WIDTH:     prdata = 32'(src_width_q);
			REG_CROP_TOP:      prdata = 32'(crop_top_q);
			REG_CROP_LEFT:     prdata = 32'(crop_left_q);
			REG_CROP_HEIGHT:   prdata = 32'(crop_height_q);
			REG_CROP_WIDTH:    prdata = 32'(crop_width_q);
			REG_TARGET_HEIGHT: prdata = 32'(target_height_q);
			REG_TARGET_WIDTH:  prdata = 32'(target_width_q);
			default:           prdata = '0;
		endcase
	end

	// effective geometry and step dividers
	geom_t             geom;
	logic              win_err;
	logic [SZ_W-1:0]   den_y, den_x, chm1, cwm1;
	logic [STEP_W-1:0] num_y, num_x, quot_y, quot_x;
	logic              busy_y, busy_x, recalc_q, div_start, step_ok;

	always_comb begin
		geom.sh   = size_eff(src_height_q);
		geom.sw   = size_eff(src_width_q);
		geom.ch   = size_eff(crop_height_q);
		geom.cw   = size_eff(crop_width_q);
		geom.th   = size_eff(target_height_q);
		geom.tw   = size_eff(target_width_q);
		geom.top  = crop_top_q;
		geom.left = crop_left_q;
		geom.step_y = (geom.th == SZ_W'(1)) ? '0 : quot_y;
		geom.step_x = (geom.tw == SZ_W'(1)) ? '0 : quot_x;
	end

	assign win_err = ((SZ_W+1)'(crop_top_q) + (SZ_W+1)'(geom.ch) > (SZ_W+1)'(geom.sh))
		|| ((SZ_W+1)'(crop_left_q) + (SZ_W+1)'(geom.cw) > (SZ_W+1)'(geom.sw));

	assign den_y = geom.th - SZ_W'(1);
	assign den_x = geom.tw - SZ_W'(1);
	assign chm1  = geom.ch - SZ_W'(1);
	assign cwm1  = geom.cw - SZ_W'(1);
	assign num_y = {chm1, {FRAC_W{1'b0}}} + STEP_W'(den_y >> 1);
	assign num_x = {cwm1, {FRAC_W{1'b0}}} + STEP_W'(den_x >> 1);

	assign div_start = recalc_q && !busy_y && !busy_x;
	assign step_ok   = !recalc_q && !busy_y && !busy_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recalc_q <= 1'b1;
		end else if (cfg_wr) begin
			recalc_q <= 1'b1;
		end else if (div_start) begin
			recalc_q <= 1'b0;
		end
	end

	bcr_stepdiv u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (den_y),
		.busy   (busy_y),
		.quot   (quot_y)
	);

	bcr_stepdiv u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (den_x),
		.busy   (busy_x),
		.quot   (quot_x)
	);

	// pipeline control
	logic   en, front_en, seq_done, c_valid;
	coord_t c_word;

	logic              v_s6;
	coord_t            item_s6;
	logic [CNT_W-1:0]  cnt_s6;

	assign en       = !(result_valid && result_stall);
	assign seq_done = (item_s6.kind == KIND_LOAD) || (cnt_s6 == CNT_W'(CHANNELS - 1));
	assign front_en = en && (!v_s6 || seq_done);
	assign item_stall = !(front_en && step_ok);

	bcr_coord u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (item_valid && !item_stall),
		.in_word   (item),
		.geom      (geom),
		.out_valid (c_valid),
		.out_coord (c_word)
	);

	// channel sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6   <= 1'b0;
			cnt_s6 <= '0;
		end else if (en) begin
			if (v_s6 && !seq_done) begin
				cnt_s6 <= cnt_s6 + CNT_W'(1);
			end else begin
				v_s6   <= c_valid;
				cnt_s6 <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			item_s6 <= c_word;
		end
	end

	// frame store, one copy per neighbour
	logic                          st_we, st_re;
	logic [IDX_W-1:0]              ld_idx;
	logic [NUM_NB-1:0][IDX_W-1:0]  rd_idx;
	logic [NUM_NB-1:0][Q_W-1:0]    q_s7;

	assign ld_idx = IDX_W'(item_s6.load_index);
	assign st_we  = en && v_s6 && (item_s6.kind == KIND_LOAD)
		&& ({16'b0, item_s6.load_index} < 32'(DEPTH));
	assign st_re  = en && v_s6 && (item_s6.kind == KIND_RESAMPLE);

	for (genvar k = 0; k < NUM_NB; k++) begin : g_store
		assign rd_idx[k] = IDX_W'(item_s6.pix[k]) * IDX_W'(CHANNELS) + IDX_W'(cnt_s6);

		bcr_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
			.clk   (clk),
			.we    (st_we),
			.waddr (ld_idx[AW-1:0]),
			.wdata (item_s6.load_value),
			.re    (st_re),
			.raddr (rd_idx[k][AW-1:0]),
			.rdata (q_s7[k])
		);
	end

	logic                        v_s7, last_s7, err_s7;
	logic [1:0]                  ch_s7;
	logic [NUM_NB-1:0][W_W-1:0]  w_s7;
	blend_t                      blend_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6 && (item_s6.kind == KIND_RESAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s7   <= 2'(cnt_s6);
			last_s7 <= cnt_s6 == CNT_W'(CHANNELS - 1);
			err_s7  <= win_err;
			w_s7    <= item_s6.w;
		end
	end

	always_comb begin
		blend_in.channel      = ch_s7;
		blend_in.last         = last_s7;
		blend_in.window_error = err_s7;
		blend_in.w            = w_s7;
		blend_in.q            = q_s7;
	end

	bcr_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_blend  (blend_in),
		.out_valid (result_valid),
		.out_word  (result)
	);

	a_accept_step_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> step_ok)
		else $error("item accepted while step dividers busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> cnt_s6 <= CNT_W'(CHANNELS - 1))
		else $error("channel counter out of range");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> result.channel == 2'(CHANNELS - 1))
		else $error("last flag on wrong channel");

	a_seq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cnt_s6))
		else $error("sequencer moved during stall");

endmodule
